[hdl/ll1_token_syntax_checker_defines.svh]
// Assertion macros for the checker file of the LL(1) token syntax checker.
// No dependencies; include by bare file name.
`ifndef LL1_TOKEN_SYNTAX_CHECKER_DEFINES_SVH
`define LL1_TOKEN_SYNTAX_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LL1_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define LL1_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/ll1tsc_pkg.sv]
// Package for the LL(1) token syntax checker: sizes, symbol codes, status and
// state types, and the LL(1) production table. No dependencies.
`default_nettype none

package ll1tsc_pkg;

    // Stack sizing
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);

    // Field widths
    localparam int TOK_W       = 5;
    localparam int SYM_W       = 6;
    localparam int DEPTH_W     = 7;

    // Production right-hand sides
    localparam int RHS_MAX     = 7;
    localparam int LEN_W       = 3;

    typedef logic [SYM_W-1:0] sym_t;
    typedef logic [TOK_W-1:0] tok_t;

    // Terminals
    localparam sym_t T_LET    = 6'd0;
    localparam sym_t T_ID     = 6'd1;
    localparam sym_t T_IF     = 6'd2;
    localparam sym_t T_GOTO   = 6'd3;
    localparam sym_t T_PRINT  = 6'd4;
    localparam sym_t T_INPUT  = 6'd5;
    localparam sym_t T_END    = 6'd6;
    localparam sym_t T_ASSIGN = 6'd7;
    localparam sym_t T_COLON  = 6'd8;
    localparam sym_t T_NUM    = 6'd9;
    localparam sym_t T_UMINUS = 6'd10;
    localparam sym_t T_LB     = 6'd11;
    localparam sym_t T_RB     = 6'd12;
    localparam sym_t T_PLUS   = 6'd13;
    localparam sym_t T_MINUS  = 6'd14;
    localparam sym_t T_MUL    = 6'd15;
    localparam sym_t T_DIV    = 6'd16;
    localparam sym_t T_RELOP  = 6'd17;
    localparam sym_t T_DELIM  = 6'd18;

    // Nonterminals; every code from N_P up is a nonterminal
    localparam sym_t N_P      = 6'd20;
    localparam sym_t N_IR     = 6'd21;
    localparam sym_t N_I      = 6'd22;
    localparam sym_t N_D      = 6'd23;
    localparam sym_t N_S      = 6'd24;
    localparam sym_t N_LAS    = 6'd25;
    localparam sym_t N_LA     = 6'd26;
    localparam sym_t N_IFS    = 6'd27;
    localparam sym_t N_GOTOS  = 6'd28;
    localparam sym_t N_PRS    = 6'd29;
    localparam sym_t N_INS    = 6'd30;
    localparam sym_t N_E      = 6'd31;
    localparam sym_t N_ER     = 6'd32;
    localparam sym_t N_T      = 6'd33;
    localparam sym_t N_TR     = 6'd34;
    localparam sym_t N_F      = 6'd35;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_ACCEPT   = 2'd1,
        STAT_ERROR    = 2'd2,
        STAT_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_INIT0,
        ST_INIT1,
        ST_IDLE,
        ST_LOOK,
        ST_PUSH,
        ST_READ
    } state_t;

    // One table entry: ok is low where the table has no entry.
    // rhs[0] is the leftmost symbol and ends up on top of the stack.
    typedef struct packed {
        logic                          ok;
        logic [LEN_W-1:0]              len;
        logic [RHS_MAX-1:0][SYM_W-1:0] rhs;
    } prod_t;

    function automatic prod_t production(sym_t nt, tok_t a);
        prod_t p;
        sym_t  as;
        logic  stmt;
        logic  expr;
        logic  fol;
        p    = '0;
        as   = sym_t'(a);
        stmt = (as <= T_INPUT);
        expr = (as == T_ID) || (as == T_NUM) || (as == T_UMINUS) || (as == T_LB);
        fol  = (as == T_RELOP) || (as == T_RB) || (as == T_GOTO) || (as == T_DELIM);
        unique case (nt)
            N_P:
            begin
                if (stmt)
                begin
                    p.ok = 1'b1; p.len = 3'd1; p.rhs[0] = N_IR;
                end
                else if (as == T_END)
                begin
                    p.ok = 1'b1;
                end
            end
            N_IR:
            begin
                if (stmt)
                begin
                    p.ok = 1'b1; p.len = 3'd2; p.rhs[0] = N_I; p.rhs[1] = N_IR;
                end
                else if (as == T_END)
                begin
                    p.ok = 1'b1;
                end
            end
            N_I:
            begin
                if (as == T_LET)
                begin
                    p.ok = 1'b1; p.len = 3'd1; p.rhs[0] = N_D;
                end
                else if (stmt)
                begin
                    p.ok = 1'b1; p.len = 3'd1; p.rhs[0] = N_S;
                end
            end
            N_D:
            begin
                if (as == T_LET)
                begin
                    p.ok = 1'b1; p.len = 3'd5;
                    p.rhs[0] = T_LET; p.rhs[1] = T_ID; p.rhs[2] = T_ASSIGN;
                    p.rhs[3] = N_E;   p.rhs[4] = T_DELIM;
                end
            end
            N_S:
            begin
                p.ok  = 1'b1;
                p.len = 3'd1;
                priority if (as == T_ID)    p.rhs[0] = N_LAS;
                else if (as == T_IF)        p.rhs[0] = N_IFS;
                else if (as == T_GOTO)      p.rhs[0] = N_GOTOS;
                else if (as == T_PRINT)     p.rhs[0] = N_PRS;
                else if (as == T_INPUT)     p.rhs[0] = N_INS;
                else                        p.ok     = 1'b0;
            end
            N_LAS:
            begin
                if (as == T_ID)
                begin
                    p.ok = 1'b1; p.len = 3'd2; p.rhs[0] = T_ID; p.rhs[1] = N_LA;
                end
            end
            N_LA:
            begin
                if (as == T_ASSIGN)
                begin
                    p.ok = 1'b1; p.len = 3'd3;
                    p.rhs[0] = T_ASSIGN; p.rhs[1] = N_E; p.rhs[2] = T_DELIM;
                end
                else if (as == T_COLON)
                begin
                    p.ok = 1'b1; p.len = 3'd1; p.rhs[0] = T_COLON;
                end
            end
            N_IFS:
            begin
                if (as == T_IF)
                begin
                    p.ok = 1'b1; p.len = 3'd7;
                    p.rhs[0] = T_IF;   p.rhs[1] = N_E;  p.rhs[2] = T_RELOP;
                    p.rhs[3] = N_E;    p.rhs[4] = T_GOTO; p.rhs[5] = T_ID;
                    p.rhs[6] = T_DELIM;
                end
            end
            N_GOTOS, N_PRS, N_INS:
            begin
                if ((nt == N_GOTOS && as == T_GOTO) || (nt == N_PRS && as == T_PRINT)
                    || (nt == N_INS && as == T_INPUT))
                begin
                    p.ok = 1'b1; p.len = 3'd3;
                    p.rhs[0] = as; p.rhs[1] = T_ID; p.rhs[2] = T_DELIM;
                end
            end
            N_E, N_T:
            begin
                if (expr)
                begin
                    p.ok = 1'b1; p.len = 3'd2;
                    p.rhs[0] = (nt == N_E) ? N_T : N_F;
                    p.rhs[1] = (nt == N_E) ? N_ER : N_TR;
                end
            end
            N_ER:
            begin
                if (as == T_PLUS || as == T_MINUS)
                begin
                    p.ok = 1'b1; p.len = 3'd3;
                    p.rhs[0] = as; p.rhs[1] = N_T; p.rhs[2] = N_ER;
                end
                else if (fol)
                begin
                    p.ok = 1'b1;
                end
            end
            N_TR:
            begin
                if (as == T_MUL || as == T_DIV)
                begin
                    p.ok = 1'b1; p.len = 3'd3;
                    p.rhs[0] = as; p.rhs[1] = N_F; p.rhs[2] = N_TR;
                end
                else if (fol || as == T_PLUS || as == T_MINUS)
                begin
                    p.ok = 1'b1;
                end
            end
            N_F:
            begin
                if (as == T_ID || as == T_NUM)
                begin
                    p.ok = 1'b1; p.len = 3'd1; p.rhs[0] = as;
                end
                else if (as == T_LB)
                begin
                    p.ok = 1'b1; p.len = 3'd3;
                    p.rhs[0] = T_LB; p.rhs[1] = N_E; p.rhs[2] = T_RB;
                end
                else if (as == T_UMINUS)
                begin
                    p.ok = 1'b1; p.len = 3'd2; p.rhs[0] = T_UMINUS; p.rhs[1] = N_F;
                end
            end
            default:
            begin
                p.ok = 1'b0;
            end
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[hdl/ll1tsc_tok_if.sv]
// Token input channel: valid/ready handshake carrying one token code per beat.
// Depends on ll1tsc_pkg.
`default_nettype none

interface ll1tsc_tok_if;
    logic                 valid;
    logic                 ready;
    ll1tsc_pkg::tok_t     token_code;

    modport source (output valid, output token_code, input ready);
    modport sink   (input valid, input token_code, output ready);
endinterface

`default_nettype wire

[hdl/ll1tsc_res_if.sv]
// Result output channel: valid/ready handshake carrying status and stack depth.
// Depends on ll1tsc_pkg.
`default_nettype none

interface ll1tsc_res_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         status;
    logic [ll1tsc_pkg::DEPTH_W-1:0]     stack_depth;

    modport source (output valid, output status, output stack_depth, input ready);
    modport sink   (input valid, input status, input stack_depth, output ready);
endinterface

`default_nettype wire

[hdl/ll1tsc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module ll1tsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read (old data on a same-address collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/ll1_token_syntax_checker.sv]
// LL(1) token syntax checker top level: symbol stack in a RAM, expanded by
// the production table. Depends on ll1tsc_pkg, ll1tsc_tok_if, ll1tsc_res_if, ll1tsc_ram.
//
//   channel | dir | beat payload              | handshake
//   tok     | in  | token_code[4:0]           | valid/ready
//   res     | out | status[1:0], stack_depth  | valid/ready
//
// When a terminal is already on top of the stack, a token needs only the
// accept beat and the stack read. Each expansion of a nonterminal adds one RAM
// write per right-hand-side symbol, then a re-read of the top.
// One token is in work at a time; the result register lets the next token
// come in while a result waits. After reset, ST_INIT0 and ST_INIT1 write the initial
// stack before tok.ready rises. A stalled result holds the finishing token in place.
`default_nettype none

module ll1_token_syntax_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    ll1tsc_tok_if.sink        tok,
    ll1tsc_res_if.source      res
);

    ll1tsc_pkg::state_t                  state_reg, state_next;
    logic [ll1tsc_pkg::SP_W-1:0]         sp_reg, sp_next;
    logic                                out_valid_reg, out_valid_next;
    ll1tsc_pkg::tok_t                    tok_reg, tok_next;
    ll1tsc_pkg::prod_t                   prod_reg, prod_next;
    logic [ll1tsc_pkg::LEN_W-1:0]        cnt_reg, cnt_next;
    ll1tsc_pkg::status_t                 status_reg, status_next;
    logic [ll1tsc_pkg::DEPTH_W-1:0]      depth_reg, depth_next;

    logic                                ram_we;
    logic [ll1tsc_pkg::ADDR_W-1:0]       ram_waddr;
    ll1tsc_pkg::sym_t                    ram_wdata;
    logic [ll1tsc_pkg::SP_W-1:0]         rd_ptr;
    ll1tsc_pkg::sym_t                    ram_rdata;

    ll1tsc_pkg::sym_t                    top_sym;
    ll1tsc_pkg::prod_t                   prod_c;
    logic                                is_term;
    logic [ll1tsc_pkg::SP_W:0]           grow;
    logic                                overflow;
    logic                                slot_free;
    logic                                finish;
    ll1tsc_pkg::status_t                 fin_status;
    logic [ll1tsc_pkg::SP_W-1:0]         fin_sp;

    // Symbol stack
    ll1tsc_ram #(
        .WIDTH (ll1tsc_pkg::SYM_W),
        .DEPTH (ll1tsc_pkg::STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_ptr[ll1tsc_pkg::ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Top-of-stack read is always issued at sp-1
    assign rd_ptr  = sp_reg - 1'b1;
    assign top_sym = (sp_reg == '0) ? ll1tsc_pkg::T_END : ram_rdata;
    assign is_term = (top_sym < ll1tsc_pkg::N_P);
    assign prod_c  = ll1tsc_pkg::production(top_sym, tok_reg);

    // Depth after the expansion: sp - 1 + len
    assign grow     = {1'b0, sp_reg} - 1'b1 + (ll1tsc_pkg::SP_W + 1)'(prod_c.len);
    assign overflow = (grow > (ll1tsc_pkg::SP_W + 1)'(ll1tsc_pkg::STACK_DEPTH));

    assign slot_free = !out_valid_reg || res.ready;

    // Ports
    assign tok.ready       = (state_reg == ll1tsc_pkg::ST_IDLE);
    assign res.valid       = out_valid_reg;
    assign res.status      = status_reg;
    assign res.stack_depth = depth_reg;

    // Next state and stack access
    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        out_valid_next = out_valid_reg && !res.ready;
        tok_next       = tok_reg;
        prod_next      = prod_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        depth_next     = depth_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = ll1tsc_pkg::T_END;
        finish         = 1'b0;
        fin_status     = ll1tsc_pkg::STAT_ERROR;
        fin_sp         = ll1tsc_pkg::SP_W'(2);

        unique case (state_reg)
            ll1tsc_pkg::ST_INIT0:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = ll1tsc_pkg::T_END;
                state_next = ll1tsc_pkg::ST_INIT1;
            end
            ll1tsc_pkg::ST_INIT1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ll1tsc_pkg::ADDR_W'(1);
                ram_wdata  = ll1tsc_pkg::N_P;
                state_next = ll1tsc_pkg::ST_IDLE;
            end
            ll1tsc_pkg::ST_IDLE:
            begin
                if (tok.valid)
                begin
                    tok_next   = tok.token_code;
                    state_next = ll1tsc_pkg::ST_LOOK;
                end
            end
            ll1tsc_pkg::ST_LOOK:
            begin
                priority if (is_term)
                begin
                    finish = 1'b1;
                    if (top_sym == ll1tsc_pkg::sym_t'(tok_reg))
                    begin
                        fin_status = (top_sym == ll1tsc_pkg::T_END) ?
                                     ll1tsc_pkg::STAT_ACCEPT : ll1tsc_pkg::STAT_OK;
                    end
                end
                else if (!prod_c.ok)
                begin
                    finish = 1'b1;
                end
                else if (overflow)
                begin
                    finish     = 1'b1;
                    fin_status = ll1tsc_pkg::STAT_OVERFLOW;
                end
                else
                begin
                    // pop the nonterminal, then push its right-hand side
                    sp_next = sp_reg - 1'b1;
                    if (prod_c.len == '0)
                    begin
                        state_next = ll1tsc_pkg::ST_READ;
                    end
                    else
                    begin
                        prod_next  = prod_c;
                        cnt_next   = prod_c.len;
                        state_next = ll1tsc_pkg::ST_PUSH;
                    end
                end

                // Result beat; the stack is reset unless the token was consumed
                if (finish && slot_free)
                begin
                    if (fin_status == ll1tsc_pkg::STAT_OK)
                    begin
                        fin_sp = sp_reg - 1'b1;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = ll1tsc_pkg::ADDR_W'(1);
                        ram_wdata = ll1tsc_pkg::N_P;
                    end
                    sp_next        = fin_sp;
                    out_valid_next = 1'b1;
                    status_next    = fin_status;
                    depth_next     = ll1tsc_pkg::DEPTH_W'(fin_sp);
                    state_next     = ll1tsc_pkg::ST_IDLE;
                end
            end
            ll1tsc_pkg::ST_PUSH:
            begin
                // deepest symbol first, leftmost symbol last
                ram_we    = 1'b1;
                ram_waddr = sp_reg[ll1tsc_pkg::ADDR_W-1:0];
                ram_wdata = prod_reg.rhs[cnt_reg - 1'b1];
                sp_next   = sp_reg + 1'b1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == ll1tsc_pkg::LEN_W'(1))
                begin
                    state_next = ll1tsc_pkg::ST_READ;
                end
            end
            ll1tsc_pkg::ST_READ:
            begin
                state_next = ll1tsc_pkg::ST_LOOK;
            end
            default:
            begin
                state_next = ll1tsc_pkg::ST_INIT0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ll1tsc_pkg::ST_INIT0;
            sp_reg        <= ll1tsc_pkg::SP_W'(2);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        tok_reg    <= tok_next;
        prod_reg   <= prod_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        depth_reg  <= depth_next;
    end

endmodule

`default_nettype wire

[hdl/ll1tsc_checker.sv]
// Port-level checks for the LL(1) token syntax checker, bound to its top level.
// Depends on ll1tsc_pkg and ll1_token_syntax_checker_defines.svh.
`default_nettype none
`include "ll1_token_syntax_checker_defines.svh"

module ll1tsc_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               tok_valid,
    input wire logic                               tok_ready,
    input wire logic                               res_valid,
    input wire logic                               res_ready,
    input wire logic [1:0]                         status,
    input wire logic [ll1tsc_pkg::DEPTH_W-1:0]     stack_depth
);

    logic                               tok_beat;
    logic                               stall;
    logic                               res_ok;
    logic                               res_done;
    logic                               depth_big;
    logic                               init_depth;
    logic [ll1tsc_pkg::DEPTH_W+1:0]     res_beat;

    // Handshake and payload terms used by the checks
    assign tok_beat   = tok_valid && tok_ready;
    assign stall      = res_valid && !res_ready;
    assign res_ok     = res_valid && (status == ll1tsc_pkg::STAT_OK);
    assign res_done   = res_valid && (status != ll1tsc_pkg::STAT_OK);
    assign depth_big  = (stack_depth > ll1tsc_pkg::DEPTH_W'(ll1tsc_pkg::STACK_DEPTH));
    assign init_depth = (stack_depth == ll1tsc_pkg::DEPTH_W'(2));
    assign res_beat   = {status, stack_depth};

    // Depth never exceeds the stack size
    `LL1_ASSERT_IMPL(a_depth_max, clk, rst_n, res_valid, !depth_big, "depth above stack size")

    // Accept, error and overflow leave the freshly initialized stack
    `LL1_ASSERT_IMPL(a_reinit_depth, clk, rst_n, res_done, init_depth, "stack not reinitialized")

    // A consumed token leaves the end marker in place
    `LL1_ASSERT_IMPL(a_ok_depth, clk, rst_n, res_ok, stack_depth != '0, "end marker popped")

    // One token in work at a time
    `LL1_ASSERT_NEXT(a_one_token, clk, rst_n, tok_beat, !tok_ready, "token taken while busy")

    // A stalled result beat holds
    `LL1_ASSERT_NEXT(a_res_hold, clk, rst_n, stall, res_valid && $stable(res_beat), "beat changed")

endmodule

bind ll1_token_syntax_checker ll1tsc_checker u_ll1tsc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .tok_valid   (tok.valid),
    .tok_ready   (tok.ready),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .status      (res.status),
    .stack_depth (res.stack_depth)
);

`default_nettype wire

[dv/tb_ll1_token_syntax_checker.sv]
// Self-checking testbench for the LL(1) token syntax checker: token programs in,
// status/depth beats checked against a predictor with its own symbol stack.
// Depends on ll1tsc_pkg, ll1tsc_tok_if, ll1tsc_res_if and ll1_token_syntax_checker.
module tb_ll1_token_syntax_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import ll1tsc_pkg::*;

    localparam int   CYCLE_LIMIT  = 1000000;
    localparam int   PHASE_TOKENS = 470;
    localparam int   TAIL_CYCLES  = 300;
    localparam int   RULE_CAP     = 2 * STACK_DEPTH + 16;
    localparam tok_t TOK_UNUSED   = 5'd19;
    localparam tok_t TOK_MAX      = 5'd31;

    // Right-hand side of one rule, index 0 is the leftmost symbol
    typedef logic [RHS_MAX-1:0][SYM_W-1:0] rhs_t;

    typedef struct packed {
        status_t              status;
        logic [DEPTH_W-1:0]   depth;
    } verdict_t;

    logic clk;
    logic rst_n;

    ll1tsc_tok_if tok_ch ();
    ll1tsc_res_if res_ch ();

    ll1_token_syntax_checker u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .tok   (tok_ch),
        .res   (res_ch)
    );

    // Predictor state
    sym_t     sym_stack [STACK_DEPTH];
    int       sym_sp;

    tok_t     pending_tokens [$];
    verdict_t expected_verdicts [$];
    verdict_t exp_v;
    logic     tok_took;
    logic     garble;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       mismatches;
    int       cycle_count;
    int       n_tokens;
    int       n_accept;
    int       n_error;
    int       n_overflow;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stack holds the end marker below the program symbol
    function automatic void stack_restart();
        sym_stack[0] = T_END;
        sym_stack[1] = N_P;
        sym_sp       = 2;
    endfunction

    // Rule table: fills rhs and returns its length, -1 where there is no entry
    function automatic int grammar_rule(sym_t nt, sym_t a, output rhs_t rhs);
        logic stmt;
        logic expr;
        logic fol;
        rhs  = '0;
        stmt = (a <= T_INPUT);
        expr = (a == T_ID) || (a == T_NUM) || (a == T_UMINUS) || (a == T_LB);
        fol  = (a == T_RELOP) || (a == T_RB) || (a == T_GOTO) || (a == T_DELIM);
        case (nt)
            N_P, N_IR:
            begin
                if (stmt)
                begin
                    if (nt == N_P)
                    begin
                        rhs[0] = N_IR;
                        return 1;
                    end
                    rhs[0] = N_I;
                    rhs[1] = N_IR;
                    return 2;
                end
                if (a == T_END)
                    return 0;
            end
            N_I:
            begin
                if (stmt)
                begin
                    rhs[0] = (a == T_LET) ? N_D : N_S;
                    return 1;
                end
            end
            N_D:
            begin
                if (a == T_LET)
                begin
                    rhs = rhs_t'({T_DELIM, N_E, T_ASSIGN, T_ID, T_LET});
                    return 5;
                end
            end
            N_S:
            begin
                case (a)
                    T_ID:    rhs[0] = N_LAS;
                    T_IF:    rhs[0] = N_IFS;
                    T_GOTO:  rhs[0] = N_GOTOS;
                    T_PRINT: rhs[0] = N_PRS;
                    T_INPUT: rhs[0] = N_INS;
                    default: return -1;
                endcase
                return 1;
            end
            N_LAS:
            begin
                if (a == T_ID)
                begin
                    rhs[0] = T_ID;
                    rhs[1] = N_LA;
                    return 2;
                end
            end
            N_LA:
            begin
                if (a == T_ASSIGN)
                begin
                    rhs = rhs_t'({T_DELIM, N_E, T_ASSIGN});
                    return 3;
                end
                if (a == T_COLON)
                begin
                    rhs[0] = T_COLON;
                    return 1;
                end
            end
            N_IFS:
            begin
                if (a == T_IF)
                begin
                    rhs = {T_DELIM, T_ID, T_GOTO, N_E, T_RELOP, N_E, T_IF};
                    return 7;
                end
            end
            N_GOTOS, N_PRS, N_INS:
            begin
                if ((nt == N_GOTOS && a == T_GOTO) || (nt == N_PRS && a == T_PRINT)
                    || (nt == N_INS && a == T_INPUT))
                begin
                    rhs = rhs_t'({T_DELIM, T_ID, a});
                    return 3;
                end
            end
            N_E:
            begin
                if (expr)
                begin
                    rhs[0] = N_T;
                    rhs[1] = N_ER;
                    return 2;
                end
            end
            N_T:
            begin
                if (expr)
                begin
                    rhs[0] = N_F;
                    rhs[1] = N_TR;
                    return 2;
                end
            end
            N_ER:
            begin
                if (a == T_PLUS || a == T_MINUS)
                begin
                    rhs = rhs_t'({N_ER, N_T, a});
                    return 3;
                end
                if (fol)
                    return 0;
            end
            N_TR:
            begin
                if (a == T_MUL || a == T_DIV)
                begin
                    rhs = rhs_t'({N_TR, N_F, a});
                    return 3;
                end
                if (fol || a == T_PLUS || a == T_MINUS)
                    return 0;
            end
            N_F:
            begin
                if (a == T_ID || a == T_NUM)
                begin
                    rhs[0] = a;
                    return 1;
                end
                if (a == T_LB)
                begin
                    rhs = rhs_t'({T_RB, N_E, T_LB});
                    return 3;
                end
                if (a == T_UMINUS)
                begin
                    rhs[0] = T_UMINUS;
                    rhs[1] = N_F;
                    return 2;
                end
            end
            default:
            begin
                return -1;
            end
        endcase
        return -1;
    endfunction

    // Expand nonterminals on top, then match, accept or fail on one token
    function automatic verdict_t parse_token(tok_t code);
        verdict_t v;
        sym_t     a;
        sym_t     top;
        rhs_t     rhs;
        int       n;
        int       i;
        int       k;
        logic     settled;
        a        = {1'b0, code};
        v.status = STAT_ERROR;
        top      = T_END;
        settled  = 1'b0;
        for (i = 0; i < RULE_CAP; i++)
        begin
            top = (sym_sp > 0 && sym_sp <= STACK_DEPTH) ? sym_stack[sym_sp-1] : T_END;
            if (top < N_P)
            begin
                settled = 1'b1;
                break;
            end
            n = grammar_rule(top, a, rhs);
            if (n < 0)
                break;
            if (sym_sp - 1 + n > STACK_DEPTH)
            begin
                v.status = STAT_OVERFLOW;
                break;
            end
            sym_sp--;
            for (k = n; k > 0; k--)
            begin
                sym_stack[sym_sp] = rhs[k-1];
                sym_sp++;
            end
        end
        if (settled && top == a)
        begin
            if (a == T_END)
                v.status = STAT_ACCEPT;
            else
            begin
                v.status = STAT_OK;
                sym_sp--;
            end
        end
        if (v.status != STAT_OK)
            stack_restart();
        v.depth = sym_sp[DEPTH_W-1:0];
        return v;
    endfunction

    // Token generation; while garble is set a few tokens get replaced or dropped
    task automatic put_token(int code);
        if (garble && $urandom_range(99) < 4)
        begin
            if ($urandom_range(1) == 1)
                pending_tokens.push_back(tok_t'($urandom_range(31)));
        end
        else
            pending_tokens.push_back(tok_t'(code));
    endtask

    task automatic emit_factor(int lvl);
        int pick;
        pick = (lvl >= 3) ? $urandom_range(5) : $urandom_range(9);
        if (pick < 3)
            put_token(T_ID);
        else if (pick < 6)
            put_token(T_NUM);
        else if (pick < 8)
        begin
            put_token(T_LB);
            emit_expr(lvl + 1);
            put_token(T_RB);
        end
        else
        begin
            put_token(T_UMINUS);
            emit_factor(lvl + 1);
        end
    endtask

    task automatic emit_term(int lvl);
        emit_factor(lvl);
        repeat ($urandom_range(2))
        begin
            put_token($urandom_range(1) ? T_MUL : T_DIV);
            emit_factor(lvl);
        end
    endtask

    task automatic emit_expr(int lvl);
        emit_term(lvl);
        repeat ($urandom_range(2))
        begin
            put_token($urandom_range(1) ? T_PLUS : T_MINUS);
            emit_term(lvl);
        end
    endtask

    task automatic emit_stmt();
        int pick;
        pick = $urandom_range(6);
        case (pick)
            0:
            begin
                put_token(T_LET);
                put_token(T_ID);
                put_token(T_ASSIGN);
                emit_expr(0);
                put_token(T_DELIM);
            end
            1:
            begin
                put_token(T_ID);
                put_token(T_ASSIGN);
                emit_expr(0);
                put_token(T_DELIM);
            end
            2:
            begin
                put_token(T_ID);
                put_token(T_COLON);
            end
            3:
            begin
                put_token(T_IF);
                emit_expr(0);
                put_token(T_RELOP);
                emit_expr(0);
                put_token(T_GOTO);
                put_token(T_ID);
                put_token(T_DELIM);
            end
            default:
            begin
                put_token((pick == 4) ? T_GOTO : (pick == 5) ? T_PRINT : T_INPUT);
                put_token(T_ID);
                put_token(T_DELIM);
            end
        endcase
    endtask

    // Mostly well-formed programs; some deeply bracketed, some pure noise
    task automatic emit_program();
        int pick;
        int nest;
        pick   = $urandom_range(99);
        garble = ($urandom_range(99) < 20);
        if (pick < 8)
        begin
            nest = $urandom_range(24, 14);
            put_token(T_LET);
            put_token(T_ID);
            put_token(T_ASSIGN);
            repeat (nest) put_token(T_LB);
            put_token(T_NUM);
            repeat (nest) put_token(T_RB);
            put_token(T_DELIM);
            put_token(T_END);
        end
        else if (pick < 12)
        begin
            repeat ($urandom_range(6, 1))
                pending_tokens.push_back(tok_t'($urandom_range(31)));
        end
        else
        begin
            repeat ($urandom_range(4)) emit_stmt();
            put_token(T_END);
        end
        garble = 1'b0;
    endtask

    // Token driver: presents beats on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!tok_ch.valid || tok_took)
            begin
                if (pending_tokens.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    tok_ch.token_code <= pending_tokens.pop_front();
                    tok_ch.valid      <= 1'b1;
                end
                else
                    tok_ch.valid <= 1'b0;
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: check result beats, then predict for accepted token beats
    always @(posedge clk)
    begin
        if (!rst_n)
            tok_took <= 1'b0;
        else
        begin
            tok_took <= tok_ch.valid && tok_ch.ready;
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result beat, status %0d depth %0d",
                             $time, res_ch.status, res_ch.stack_depth);
                    mismatches++;
                end
                else
                begin
                    exp_v = expected_verdicts.pop_front();
                    if (res_ch.status !== exp_v.status)
                    begin
                        $display("%0t: status mismatch, expected %0d got %0d",
                                 $time, exp_v.status, res_ch.status);
                        mismatches++;
                    end
                    if (res_ch.stack_depth !== exp_v.depth)
                    begin
                        $display("%0t: stack_depth mismatch, expected %0d got %0d",
                                 $time, exp_v.depth, res_ch.stack_depth);
                        mismatches++;
                    end
                end
            end
            if (tok_ch.valid && tok_ch.ready)
            begin
                exp_v = parse_token(tok_ch.token_code);
                expected_verdicts.push_back(exp_v);
                n_tokens++;
                case (exp_v.status)
                    STAT_ACCEPT:   n_accept++;
                    STAT_ERROR:    n_error++;
                    STAT_OVERFLOW: n_overflow++;
                    default:       ;
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, expected_verdicts.size());
            $display("FAIL");
            $finish;
        end
    end

    // Stimulus: directed programs, then random programs under four idle/stall profiles
    initial
    begin
        int send_pct [4];
        int stall_pct [4];
        int directed [$];
        send_pct  = '{0, 83, 0, 30};
        stall_pct = '{0, 0, 83, 30};
        directed  = '{T_END,
                      T_LET, T_ID, T_ASSIGN, T_UMINUS, T_LB, T_NUM, T_MUL, T_ID, T_DIV,
                      T_NUM, T_RB, T_MINUS, T_ID, T_PLUS, T_NUM, T_DELIM,
                      T_IF, T_ID, T_RELOP, T_NUM, T_GOTO, T_ID, T_DELIM,
                      T_ID, T_COLON, T_PRINT, T_ID, T_DELIM, T_INPUT, T_ID, T_DELIM,
                      T_END,
                      TOK_MAX, TOK_UNUSED, T_DELIM, T_LET, T_END,
                      T_GOTO, T_ID, T_DELIM, T_END};
        tok_ch.valid      = 1'b0;
        tok_ch.token_code = '0;
        res_ch.ready      = 1'b0;
        rst_n             = 1'b0;
        garble            = 1'b0;
        mismatches        = 0;
        cycle_count       = 0;
        n_tokens          = 0;
        n_accept          = 0;
        n_error           = 0;
        n_overflow        = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        stack_restart();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            put_token(directed[i]);

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = stall_pct[ph];
            while (pending_tokens.size() < PHASE_TOKENS)
                emit_program();
            @(posedge clk);
            while (pending_tokens.size() != 0 || tok_ch.valid
                   || expected_verdicts.size() != 0)
                @(posedge clk);
        end

        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_verdicts.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived",
                     $time, expected_verdicts.size());
            mismatches++;
        end

        $display("Checked %0d tokens under four idle/stall profiles:", n_tokens);
        $display("  %0d programs accepted, %0d syntax errors, %0d stack overflows",
                 n_accept, n_error, n_overflow);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/ll1tsc_pkg.sv
hdl/ll1tsc_tok_if.sv
hdl/ll1tsc_res_if.sv
hdl/ll1tsc_ram.sv
hdl/ll1_token_syntax_checker.sv
hdl/ll1tsc_checker.sv
dv/tb_ll1_token_syntax_checker.sv
